// ----- sv/lpvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpvs_pkg
// Shared sizes, codes and types of the LRU page victim selector.
// ----------------------------------------------------------------------------
package lpvs_pkg;

   localparam int ENTRIES   = 8;
   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int PAGE_BITS = 20;
   localparam int TIME_BITS = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_TOUCH  = 2'd1,
      CMD_EVICT  = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_FULL      = 3'd1,
      STATUS_MISSING   = 3'd2,
      STATUS_NO_VICTIM = 3'd3,
      STATUS_DUPLICATE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic                  insert;
      logic                  touch;
      logic                  shift;
      logic [PAGE_BITS-1:0]  page;
      logic [TIME_BITS-1:0]  now;
      logic [IDX_BITS-1:0]   victim_idx;
   } cell_ctrl_type;

   typedef struct packed {
      logic                  found;
      logic [IDX_BITS-1:0]   idx;
      logic [TIME_BITS-1:0]  stamp;
      logic [PAGE_BITS-1:0]  page;
   } token_type;

endpackage

// ----- sv/lpvs_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpvs_cell
// One table slot: page, stamp and valid bit, plus one stage of the
// victim-search token that runs along the row.
// ----------------------------------------------------------------------------
module lpvs_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  lpvs_pkg::cell_ctrl_type       ctrl,
   input  logic [lpvs_pkg::IDX_BITS-1:0] cell_idx,
   input  logic                          prev_valid,
   input  logic                          next_valid,
   input  logic [lpvs_pkg::PAGE_BITS-1:0] next_page,
   input  logic [lpvs_pkg::TIME_BITS-1:0] next_stamp,
   input  lpvs_pkg::token_type           tok_in,
   output lpvs_pkg::token_type           tok_out,
   output logic                          valid,
   output logic [lpvs_pkg::PAGE_BITS-1:0] page,
   output logic [lpvs_pkg::TIME_BITS-1:0] stamp,
   output logic                          match
);
   import lpvs_pkg::*;

   logic                 valid_ff, valid_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [TIME_BITS-1:0] stamp_ff, stamp_in;
   token_type            tok_ff, tok_in_next;
   logic                 eligible;
   logic                 take;

   assign match    = valid_ff && (page_ff == ctrl.page);
   assign eligible = valid_ff && (stamp_ff <= ctrl.now);
   assign take     = eligible && (!tok_in.found || (stamp_ff < tok_in.stamp));

   always_comb begin
      if (take) begin
         tok_in_next.found = 1'b1;
         tok_in_next.idx   = cell_idx;
         tok_in_next.stamp = stamp_ff;
         tok_in_next.page  = page_ff;
      end else begin
         tok_in_next = tok_in;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      page_in  = page_ff;
      stamp_in = stamp_ff;
      if (ctrl.shift && (cell_idx >= ctrl.victim_idx)) begin
         valid_in = next_valid;
         page_in  = next_page;
         stamp_in = next_stamp;
      end else if (ctrl.insert && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         page_in  = ctrl.page;
         stamp_in = ctrl.now;
      end else if (ctrl.touch && match) begin
         stamp_in = ctrl.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.found <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         tok_ff.found <= tok_in_next.found;
      end
      page_ff      <= page_in;
      stamp_ff     <= stamp_in;
      tok_ff.idx   <= tok_in_next.idx;
      tok_ff.stamp <= tok_in_next.stamp;
      tok_ff.page  <= tok_in_next.page;
   end

   assign tok_out = tok_ff;
   assign valid   = valid_ff;
   assign page    = page_ff;
   assign stamp   = stamp_ff;

endmodule

// ----- sv/lru_page_victim_selector_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_victim_selector_top
// Timestamp LRU table of resident pages with insert, touch and evict.
// ----------------------------------------------------------------------------
// The table is a row of ENTRIES cells kept in insertion order. Insert and
// touch are accepted, then decided and applied in one step once the output
// register is free. Evict first lets the search token walk the row one cell per
// cycle, collecting the oldest eligible stamp, then the row closes the gap by
// shifting left in one step. One item is in flight at a time; a finished
// result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module lru_page_victim_selector_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // page_id[19:0], now[51:20], zero fill
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // victim_page[19:0], zero fill
   output logic [2:0]  rsp_tuser    // status[2:0]
);
   import lpvs_pkg::*;

   state_type            state_ff, state_in;
   logic [IDX_BITS-1:0]  cnt_ff, cnt_in;
   logic [1:0]           cmd_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [2:0]           rsp_status_ff, rsp_status_in;
   logic [PAGE_BITS-1:0] rsp_victim_ff, rsp_victim_in;

   logic                 accept;
   logic                 commit;
   cell_ctrl_type        ctrl;
   token_type            tok_chain [ENTRIES+1];
   token_type            best;
   logic                 valid_w   [ENTRIES];
   logic [PAGE_BITS-1:0] page_w    [ENTRIES];
   logic [TIME_BITS-1:0] stamp_w   [ENTRIES];
   logic [ENTRIES-1:0]   match_vec;
   logic                 any_match;
   logic                 full;

   assign tok_chain[0] = '0;
   assign best         = tok_chain[ENTRIES];
   assign any_match    = |match_vec;
   assign full         = valid_w[ENTRIES-1];

   genvar k;
   generate
      for (k = 0; k < ENTRIES; k++) begin : g_cell
         logic                 prev_v;
         logic                 next_v;
         logic [PAGE_BITS-1:0] next_p;
         logic [TIME_BITS-1:0] next_s;
         if (k == 0) begin : g_first
            assign prev_v = 1'b1;
         end else begin : g_mid
            assign prev_v = valid_w[k-1];
         end
         if (k == ENTRIES-1) begin : g_last
            assign next_v = 1'b0;
            assign next_p = '0;
            assign next_s = '0;
         end else begin : g_inner
            assign next_v = valid_w[k+1];
            assign next_p = page_w[k+1];
            assign next_s = stamp_w[k+1];
         end
         lpvs_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .cell_idx   (IDX_BITS'(k)),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_page  (next_p),
            .next_stamp (next_s),
            .tok_in     (tok_chain[k]),
            .tok_out    (tok_chain[k+1]),
            .valid      (valid_w[k]),
            .page       (page_w[k]),
            .stamp      (stamp_w[k]),
            .match      (match_vec[k])
         );
      end
   endgenerate

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               if (req_tuser == CMD_EVICT) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_BITS'(ENTRIES-1)) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         S_IDLE: req_tready = 1'b1;
         S_SCAN: req_tready = 1'b0;
         S_EXEC: commit     = !rsp_tvalid_ff || rsp_tready;
         default: req_tready = 1'b0;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_comb begin
      rsp_status_in = STATUS_OK;
      rsp_victim_in = '0;
      case (cmd_ff)
         CMD_INSERT: begin
            if (any_match) begin
               rsp_status_in = STATUS_DUPLICATE;
            end else if (full) begin
               rsp_status_in = STATUS_FULL;
            end
         end
         CMD_TOUCH: begin
            if (!any_match) begin
               rsp_status_in = STATUS_MISSING;
            end
         end
         CMD_EVICT: begin
            if (best.found) begin
               rsp_victim_in = best.page;
            end else begin
               rsp_status_in = STATUS_NO_VICTIM;
            end
         end
         default: rsp_status_in = STATUS_OK;
      endcase
   end

   always_comb begin
      ctrl.insert     = commit && (cmd_ff == CMD_INSERT) && !any_match && !full;
      ctrl.touch      = commit && (cmd_ff == CMD_TOUCH);
      ctrl.shift      = commit && (cmd_ff == CMD_EVICT) && best.found;
      ctrl.page       = page_ff;
      ctrl.now        = now_ff;
      ctrl.victim_idx = best.idx;
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (commit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      if (accept) begin
         cmd_ff  <= req_tuser;
         page_ff <= req_tdata[PAGE_BITS-1:0];
         now_ff  <= req_tdata[PAGE_BITS+TIME_BITS-1:PAGE_BITS];
      end
      if (commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_victim_ff <= rsp_victim_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'b0, rsp_victim_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
